/* sv/pfn_pkg.sv */
// Package with shared types and constants of the polygon face normal block.
package pfn_pkg;
  localparam int COORD_W = 16;
  localparam int OUT_W   = 16;
  localparam int NORMAL_FRAC_BITS = OUT_W - 1;

  typedef enum logic {
    REQ_POLYGON   = 1'b0,
    REQ_PRIMITIVE = 1'b1
  } req_type_t;

  typedef struct packed {
    logic                      req_type;
    logic signed [COORD_W-1:0] coord_x;
    logic signed [COORD_W-1:0] coord_y;
    logic signed [COORD_W-1:0] coord_z;
    logic                      last_vertex;
  } vertex_item_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] normal_x;
    logic signed [OUT_W-1:0] normal_y;
    logic signed [OUT_W-1:0] normal_z;
    logic                    degenerate;
  } normal_item_t;
endpackage

/* sv/pfn_vertex_if.sv */
// Valid/ready channel that carries one vertex item.
interface pfn_vertex_if;
  import pfn_pkg::*;
  logic         valid;
  logic         ready;
  vertex_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* sv/pfn_normal_if.sv */
// Valid/ready channel that carries one normal item.
interface pfn_normal_if;
  import pfn_pkg::*;
  logic         valid;
  logic         ready;
  normal_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* sv/polygon_face_normal_top.sv */
// Top level of the polygon face normal block: sequencer around one shared ALU.
//
// Vertex items enter on channel vin, results leave on channel nout.
// Each polygon vertex forms one corner cross product with a single shared
// saturating multiplier and adder: six products, three differences and three
// sums, during which vin.ready stays low. The first two vertices of a
// polygon only get stored, and unless the polygon ends there, vin.ready
// stays high after them.
// A primitive item or a short polygon gives the default normal (0,0,1) with
// degenerate set; it passes through the last state into the output register.
// The last vertex adds the two closing corners, then normalizes: the
// magnitudes, a shift search one bit per cycle, three squares, a restoring
// square root at one bit per cycle and three restoring divides at one bit
// per cycle. The result sits in an output register until nout.ready takes
// it; the next item is taken meanwhile, but a finished result waits in the
// last state, with vin.ready low, until the register is free.
// Synchronous reset clears the polygon state.
module polygon_face_normal_top #(
  parameter int SUM_BITS = 48
) (
  input logic clk,
  input logic rst,
  pfn_vertex_if.sink   vin,
  pfn_normal_if.source nout
);
  import pfn_pkg::*;

  localparam int SW = SUM_BITS;
  localparam logic signed [SW-1:0] SMAX = {1'b0, {(SW-1){1'b1}}};
  localparam logic signed [SW-1:0] SMIN = {1'b1, {(SW-1){1'b0}}};
  localparam logic [63:0] UNIT = (64'd1 << NORMAL_FRAC_BITS) - 64'd1;
  localparam logic [63:0] HI = 64'd1 << 30;
  localparam logic [63:0] LO = 64'd1 << 29;

  typedef enum logic [3:0] {
    S_IDLE, S_CORNER, S_NORM_MAG, S_SHIFT, S_SQ, S_ROOT, S_DIV, S_OUT
  } state_t;

  typedef logic signed [COORD_W:0] diff_t;

  state_t state;
  logic signed [COORD_W-1:0] fv [3];
  logic signed [COORD_W-1:0] sv2 [3];
  logic signed [COORD_W-1:0] ov [3];
  logic signed [COORD_W-1:0] nv [3];
  logic signed [SW-1:0] nsum [3];
  logic [15:0] vcount;
  logic closing;
  logic [1:0] corner;      // corners still to add at the last vertex
  logic [3:0] step;
  diff_t a [3];
  diff_t b [3];
  logic signed [SW-1:0] prod;
  logic [63:0] t [3];
  logic [63:0] acc;
  logic [63:0] rem;
  logic [63:0] root;
  logic [63:0] bitv;
  logic [63:0] quo;
  logic [63:0] den;
  logic [6:0] cnt;
  logic [1:0] comp;
  logic out_valid;
  normal_item_t out_data;
  normal_item_t res;
  logic out_load;

  // Shared ALU: saturating signed multiply of two differences.
  function automatic logic signed [SW-1:0] smul(diff_t x, diff_t y);
    logic signed [2*COORD_W+1:0] p;
    logic signed [SW:0] pe;
    p = x * y;
    pe = (SW+1)'(p);
    if ((2*COORD_W+2) > SW) begin
      if (p > (2*COORD_W+2)'(SMAX)) return SMAX;
      if (p < (2*COORD_W+2)'(SMIN)) return SMIN;
    end
    return pe[SW-1:0];
  endfunction

  function automatic logic signed [SW-1:0] sadd(logic signed [SW-1:0] x,
                                                logic signed [SW-1:0] y, logic sub);
    logic signed [SW:0] s;
    s = sub ? ({x[SW-1], x} - {y[SW-1], y}) : ({x[SW-1], x} + {y[SW-1], y});
    if (s[SW] != s[SW-1]) return s[SW] ? SMIN : SMAX;
    return s[SW-1:0];
  endfunction

  function automatic logic [63:0] umag(logic signed [SW-1:0] v);
    logic [63:0] e;
    e = 64'($signed(v));
    return v[SW-1] ? (64'd0 - e) : e;
  endfunction

  wire vin_fire = vin.valid && vin.ready;
  assign vin.ready = (state == S_IDLE);
  assign nout.valid = out_valid;
  assign nout.data = out_data;
  assign out_load = (state == S_OUT) && (!out_valid || nout.ready);

  logic [63:0] mx;
  logic [63:0] trial;
  always_comb begin
    mx = t[0];
    if (t[1] > mx) mx = t[1];
    if (t[2] > mx) mx = t[2];
    trial = root + bitv;
  end

  // Sets up the corner (p, c, q) difference vectors.
  task automatic load_corner(input logic signed [COORD_W-1:0] p [3],
                             input logic signed [COORD_W-1:0] c [3],
                             input logic signed [COORD_W-1:0] q [3]);
    for (int i = 0; i < 3; i++) begin
      a[i] <= diff_t'(q[i]) - diff_t'(c[i]);
      b[i] <= diff_t'(p[i]) - diff_t'(c[i]);
    end
  endtask

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      vcount <= '0;
      closing <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        fv[i] <= '0; sv2[i] <= '0; ov[i] <= '0; nv[i] <= '0; nsum[i] <= '0;
      end
    end else begin
      if (out_load) out_valid <= 1'b1;
      else if (nout.ready) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (vin_fire) begin
            if (vin.data.req_type == REQ_PRIMITIVE) begin
              res <= '{normal_x: '0, normal_y: '0,
                       normal_z: OUT_W'(UNIT), degenerate: 1'b1};
              state <= S_OUT;
            end else begin
              if (vcount == 16'd0) begin
                fv <= '{COORD_W'(vin.data.coord_x), COORD_W'(vin.data.coord_y),
                        COORD_W'(vin.data.coord_z)};
              end else if (vcount == 16'd1) begin
                sv2 <= '{COORD_W'(vin.data.coord_x), COORD_W'(vin.data.coord_y),
                         COORD_W'(vin.data.coord_z)};
              end
              load_corner(ov, nv, '{COORD_W'(vin.data.coord_x),
                          COORD_W'(vin.data.coord_y), COORD_W'(vin.data.coord_z)});
              ov <= nv;
              nv <= '{COORD_W'(vin.data.coord_x), COORD_W'(vin.data.coord_y),
                      COORD_W'(vin.data.coord_z)};
              if (vcount != 16'hFFFF) vcount <= vcount + 16'd1;
              closing <= vin.data.last_vertex;
              step <= '0;
              corner <= 2'd2;
              if (vcount >= 16'd2) state <= S_CORNER;
              else if (vin.data.last_vertex) begin
                // Too few vertices: the output state clears sum and count.
                res <= '{normal_x: '0, normal_y: '0,
                         normal_z: OUT_W'(UNIT), degenerate: 1'b1};
                state <= S_OUT;
              end
            end
          end
        end
        S_CORNER: begin
          // Per component: product, product, difference, accumulate.
          step <= (step == 4'd8) ? 4'd0 : step + 4'd1;
          unique case (step)
            4'd0: prod <= smul(a[1], b[2]);
            4'd1: prod <= sadd(prod, smul(a[2], b[1]), 1'b1);
            4'd2: nsum[0] <= sadd(nsum[0], prod, 1'b0);
            4'd3: prod <= smul(a[2], b[0]);
            4'd4: prod <= sadd(prod, smul(a[0], b[2]), 1'b1);
            4'd5: nsum[1] <= sadd(nsum[1], prod, 1'b0);
            4'd6: prod <= smul(a[0], b[1]);
            4'd7: prod <= sadd(prod, smul(a[1], b[0]), 1'b1);
            default: begin
              nsum[2] <= sadd(nsum[2], prod, 1'b0);
              if (!closing) state <= S_IDLE;
              else if (corner == 2'd2) begin
                load_corner(ov, nv, fv);
                corner <= 2'd1;
              end else if (corner == 2'd1) begin
                load_corner(nv, fv, sv2);
                corner <= 2'd0;
              end else state <= S_NORM_MAG;
            end
          endcase
        end
        S_NORM_MAG: begin
          for (int i = 0; i < 3; i++) t[i] <= umag(nsum[i]);
          state <= S_SHIFT;
        end
        S_SHIFT: begin
          if (mx == 64'd0) begin
            res <= '{normal_x: '0, normal_y: '0,
                     normal_z: OUT_W'(UNIT), degenerate: 1'b1};
            state <= S_OUT;
          end else if (mx >= HI) begin
            for (int i = 0; i < 3; i++) t[i] <= t[i] >> 1;
          end else if (mx < LO) begin
            for (int i = 0; i < 3; i++) t[i] <= t[i] << 1;
          end else begin
            acc <= '0;
            comp <= '0;
            state <= S_SQ;
          end
        end
        S_SQ: begin
          acc <= acc + t[comp][31:0] * t[comp][31:0];
          if (comp == 2'd2) begin
            root <= '0;
            bitv <= 64'd1 << 62;
            state <= S_ROOT;
          end
          comp <= comp + 2'd1;
        end
        S_ROOT: begin
          // acc holds the part of the sum of squares not yet taken by the root.
          if (bitv == 64'd0) begin
            den <= {root[62:0], 1'b0};
            comp <= '0;
            cnt <= 7'd0;
            state <= S_DIV;
          end else begin
            if (acc >= trial) begin
              acc <= acc - trial;
              root <= (root >> 1) + bitv;
            end else root <= root >> 1;
            bitv <= bitv >> 2;
          end
        end
        S_DIV: begin
          if (cnt == 7'd0) begin
            rem <= '0;
            quo <= (t[comp] << (NORMAL_FRAC_BITS + 1)) + (den >> 1);
            cnt <= 7'd1;
          end else if (cnt <= 7'd64) begin
            if ({rem[62:0], quo[63]} >= den) begin
              rem <= {rem[62:0], quo[63]} - den;
              quo <= {quo[62:0], 1'b1};
            end else begin
              rem <= {rem[62:0], quo[63]};
              quo <= {quo[62:0], 1'b0};
            end
            cnt <= cnt + 7'd1;
          end else begin
            logic [63:0] v;
            logic [OUT_W-1:0] o;
            v = (quo > UNIT) ? UNIT : quo;
            o = nsum[comp][SW-1] ? OUT_W'(64'd0 - v) : OUT_W'(v);
            unique case (comp)
              2'd0: res.normal_x <= o;
              2'd1: res.normal_y <= o;
              default: res.normal_z <= o;
            endcase
            cnt <= 7'd0;
            comp <= comp + 2'd1;
            if (comp == 2'd2) begin
              res.degenerate <= 1'b0;
              state <= S_OUT;
            end
          end
        end
        S_OUT: begin
          if (out_load) begin
            out_data <= res;
            if (closing) begin
              for (int i = 0; i < 3; i++) nsum[i] <= '0;
              vcount <= '0;
            end
            closing <= 1'b0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !vin.ready) else $error("accept while busy");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !nout.ready) |=> out_valid) else $error("result dropped");
  a_degen_default: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.degenerate) |-> (out_data.normal_x == '0))
    else $error("bad default normal");
endmodule

/* tb/polygon_face_normal_top_tb.sv */
// Testbench for the polygon face normal block: vertex streams against a face normal predictor.
`timescale 1ns / 1ps
module polygon_face_normal_top_tb;
  import pfn_pkg::*;

  localparam int FRAC = 15;
  localparam longint SUM_MAX = (64'sd1 <<< 47) - 1;
  localparam longint SUM_MIN = -SUM_MAX - 1;
  localparam longint UNIT_MAX = (64'sd1 <<< FRAC) - 1;
  localparam int LIMIT = 3000000;

  typedef struct {
    longint x;
    longint y;
    longint z;
  } point_t;

  // Face normal predictor with its own copy of the polygon state.
  class normal_scoreboard;
    point_t head_pt, second_pt, prev_pt, last_pt;
    longint acc[3];
    int unsigned count;
    normal_item_t pending[$];
    int errors;

    function void clear();
      head_pt = '{0, 0, 0};
      second_pt = head_pt;
      prev_pt = head_pt;
      last_pt = head_pt;
      acc = '{0, 0, 0};
      count = 0;
      pending.delete();
      errors = 0;
    endfunction

    function longint sadd(longint a, longint b);
      longint s;
      s = a + b;
      if (s > SUM_MAX) return SUM_MAX;
      if (s < SUM_MIN) return SUM_MIN;
      return s;
    endfunction

    function longint smul(longint a, longint b);
      // Differences of 16-bit values fit in 17 bits, so the product is exact in 64 bits.
      return sadd(a * b, 0);
    endfunction

    function void add_corner(point_t p, point_t c, point_t q);
      longint ax, ay, az, bx, by, bz;
      ax = q.x - c.x; ay = q.y - c.y; az = q.z - c.z;
      bx = p.x - c.x; by = p.y - c.y; bz = p.z - c.z;
      acc[0] = sadd(acc[0], sadd(smul(ay, bz), -smul(az, by)));
      acc[1] = sadd(acc[1], sadd(smul(az, bx), -smul(ax, bz)));
      acc[2] = sadd(acc[2], sadd(smul(ax, by), -smul(ay, bx)));
    endfunction

    function longint unsigned root(longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v -= r + b;
          r = (r >> 1) + b;
        end else begin
          r >>= 1;
        end
        b >>= 2;
      end
      return r;
    endfunction

    function normal_item_t default_normal();
      normal_item_t n;
      n.normal_x = '0;
      n.normal_y = '0;
      n.normal_z = UNIT_MAX[15:0];
      n.degenerate = 1'b1;
      return n;
    endfunction

    function normal_item_t unit_normal();
      longint unsigned t[3], m, len, v;
      logic [15:0] comp[3];
      normal_item_t n;
      m = 0;
      for (int i = 0; i < 3; i++) begin
        t[i] = acc[i] < 0 ? -acc[i] : acc[i];
        if (t[i] > m) m = t[i];
      end
      if (m == 0) return default_normal();
      while (m >= (64'd1 << 30)) begin
        m >>= 1;
        for (int i = 0; i < 3; i++) t[i] >>= 1;
      end
      while (m < (64'd1 << 29)) begin
        m <<= 1;
        for (int i = 0; i < 3; i++) t[i] <<= 1;
      end
      len = root(t[0] * t[0] + t[1] * t[1] + t[2] * t[2]);
      for (int i = 0; i < 3; i++) begin
        v = ((t[i] << (FRAC + 1)) + len) / (2 * len);
        if (v > UNIT_MAX) v = UNIT_MAX;
        if (acc[i] < 0) v = -v;
        comp[i] = v[15:0];
      end
      n.normal_x = comp[0];
      n.normal_y = comp[1];
      n.normal_z = comp[2];
      n.degenerate = 1'b0;
      return n;
    endfunction

    function void note_vertex(vertex_item_t it);
      point_t v;
      if (it.req_type == REQ_PRIMITIVE) begin
        pending.push_back(default_normal());
        return;
      end
      v.x = it.coord_x; v.y = it.coord_y; v.z = it.coord_z;
      if (count == 0) head_pt = v;
      else if (count == 1) second_pt = v;
      else add_corner(prev_pt, last_pt, v);
      prev_pt = last_pt;
      last_pt = v;
      if (count < 65535) count++;
      if (!it.last_vertex) return;
      if (count < 3) begin
        pending.push_back(default_normal());
      end else begin
        add_corner(prev_pt, last_pt, head_pt);
        add_corner(last_pt, head_pt, second_pt);
        pending.push_back(unit_normal());
      end
      acc = '{0, 0, 0};
      count = 0;
    endfunction

    function void check_normal(normal_item_t got);
      normal_item_t want;
      if (pending.size() == 0) begin
        report("normal item with none expected", 0, 0);
        return;
      end
      want = pending.pop_front();
      if (got.normal_x !== want.normal_x) report("normal_x", got.normal_x, want.normal_x);
      if (got.normal_y !== want.normal_y) report("normal_y", got.normal_y, want.normal_y);
      if (got.normal_z !== want.normal_z) report("normal_z", got.normal_z, want.normal_z);
      if (got.degenerate !== want.degenerate)
        report("degenerate", got.degenerate, want.degenerate);
    endfunction

    function void report(string what, longint got, longint want);
      $display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $realtime);
      errors++;
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  pfn_vertex_if vin();
  pfn_normal_if nout();
  normal_scoreboard board;
  bit quiet_tail;
  bit hold_sink;
  int cycles;

  polygon_face_normal_top i_dut (.clk(clk), .rst(rst), .vin(vin.sink), .nout(nout.source));

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("polygon_face_normal_top_tb failed");
      $finish;
    end
  end

  // Sampling at the rising edge, before the falling-edge drivers move anything.
  always @(posedge clk) begin
    if (!rst && vin.valid && vin.ready) board.note_vertex(vin.data);
    if (!rst && nout.valid && nout.ready) board.check_normal(nout.data);
  end

  // Receiver with random stall bursts and one long hold-off on request.
  initial begin
    int gap;
    nout.ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_sink) begin
        nout.ready <= 1'b0;
        repeat (3000) @(negedge clk);
        hold_sink = 1'b0;
      end
      if (!quiet_tail && $urandom_range(3) == 0) begin
        nout.ready <= 1'b0;
        gap = $urandom_range(7, 1);
        repeat (gap) @(negedge clk);
      end
      nout.ready <= 1'b1;
      @(negedge clk);
    end
  end

  task automatic send(vertex_item_t it);
    int gap;
    if (!quiet_tail && $urandom_range(4) == 0) begin
      vin.valid <= 1'b0;
      gap = $urandom_range(7, 1);
      repeat (gap) @(negedge clk);
    end
    vin.data <= it;
    vin.valid <= 1'b1;
    @(posedge clk);
    while (!vin.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_vertex(int x, int y, int z, bit last);
    vertex_item_t it;
    it.req_type = REQ_POLYGON;
    it.coord_x = x[15:0];
    it.coord_y = y[15:0];
    it.coord_z = z[15:0];
    it.last_vertex = last;
    send(it);
  endtask

  task automatic send_primitive();
    vertex_item_t it;
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    it = raw[$bits(vertex_item_t)-1:0];
    it.req_type = REQ_PRIMITIVE;
    send(it);
  endtask

  task automatic drain();
    vin.valid <= 1'b0;
    while (board.pending.size() != 0) @(negedge clk);
  endtask

  function automatic int rand_coord(int span);
    if (span >= 32768) return int'($urandom_range(65535)) - 32768;
    return int'($urandom_range(2 * span)) - span;
  endfunction

  // Random polygon: mostly near-planar clusters, sometimes wild points.
  task automatic random_polygon(int n, bit wild);
    int span, r, cx, cy, cz;
    span = (1 << $urandom_range(15, 2));
    cx = rand_coord(32768 - span); cy = rand_coord(32768 - span); cz = rand_coord(32768 - span);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(15) == 0) send_primitive();
      if (wild)
        send_vertex(rand_coord(32768), rand_coord(32768), rand_coord(32768), i == n - 1);
      else
        send_vertex(cx + rand_coord(span), cy + rand_coord(span),
                    cz + rand_coord(span / 8), i == n - 1);
    end
  endtask

  initial begin
    int sent;
    board = new();
    board.clear();
    vin.valid = 1'b0;
    vin.data = '0;
    quiet_tail = 1'b0;
    hold_sink = 1'b0;
    cycles = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: primitive, short polygons, a triangle, extremes, zero area.
    send_primitive();
    send_vertex(5, 6, 7, 1);
    send_vertex(1, 2, 3, 0);
    send_vertex(4, 5, 6, 1);
    send_vertex(0, 0, 0, 0);
    send_vertex(100, 0, 0, 0);
    send_primitive();
    send_vertex(0, 100, 0, 1);
    send_vertex(-32768, -32768, -32768, 0);
    send_vertex(32767, -32768, 32767, 0);
    send_vertex(-32768, 32767, 32767, 0);
    send_vertex(32767, 32767, -32768, 1);
    send_vertex(1, 1, 1, 0);
    send_vertex(2, 2, 2, 0);
    send_vertex(3, 3, 3, 1);
    send_vertex(-1, -1, 0, 0);
    send_vertex(-1, 0, 0, 0);
    send_vertex(0, -1, 0, 1);
    drain();

    // Long hold-off on the receiver while vertices keep arriving.
    hold_sink = 1'b1;
    random_polygon(3, 0);
    random_polygon(4, 0);
    random_polygon(3, 1);
    drain();

    sent = 0;
    while (sent < 700) begin
      int n;
      if (sent > 600) quiet_tail = 1'b1;
      n = ($urandom_range(9) == 0) ? $urandom_range(2, 1) : $urandom_range(8, 3);
      random_polygon(n, $urandom_range(5) == 0);
      sent += n;
    end
    drain();
    repeat (400) @(negedge clk);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("polygon_face_normal_top_tb passed");
    end else begin
      $display("polygon_face_normal_top_tb failed");
    end
    $finish;
  end
endmodule
